/* design/jss_pkg.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep package
// Shared constants, configuration register codes and the structure that
// carries result requests from the stencil datapath to the output queue.
// ---------------------------------------------------------------------------
package jss_pkg;

  // Default sizing of the line store and the cell values.
  localparam int MAX_COLS    = 1024;
  localparam int VALUE_BITS  = 32;

  // Fixed widths of the configuration registers and the write port.
  localparam int ROWS_W      = 16;
  localparam int COLS_W      = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // Smallest grid side that the sweep works on.
  localparam int MIN_DIM     = 3;

  // Output queue sizing; the depth is a power of two so the pointers wrap.
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_index_t;

  // Result requests raised by one cell: the cell of the row above and, on
  // the last row, the cell itself.
  typedef struct packed {
    logic first;
    logic second;
    logic first_run_end;
    logic second_grid_end;
  } push_t;

endpackage

/* design/jss_in_if.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep input channel
// Valid/ready channel carrying one grid cell per request.
// ---------------------------------------------------------------------------
interface jss_in_if #(
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

/* design/jss_out_if.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep output channel
// Valid/ready channel carrying one updated cell and its end flags per request.
// ---------------------------------------------------------------------------
interface jss_out_if #(
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] new_value;
  logic                         run_end;
  logic                         grid_end;

  modport source (output valid, output new_value, output run_end, output grid_end,
                  input ready);
  modport sink   (input valid, input new_value, input run_end, input grid_end,
                  output ready);
endinterface

/* design/jacobi_stencil_sweep.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep
// One Jacobi relaxation sweep of a five-point stencil over a streamed grid.
// ---------------------------------------------------------------------------
// The block takes one grid cell per cycle while ready is high, in row-major
// order, and returns the relaxed grid one row behind. Interior cells become
// the floor of a quarter of their four neighbours; boundary rows and columns
// pass through. Both line buffers share one RAM of MAX_COLS entries, each
// holding the upper and the middle row of a column; the RAM is read one column
// ahead and written back in the same cycle, so a new cell is accepted every
// cycle while ready is high. A result passes the pipeline stage register and
// then the output queue. On the last grid row each cell yields two results
// through the single output channel, which there limits how fast cells are
// taken. After a column count change, requests wait for its registered copy
// while the look-ahead read catches up; the RAM needs no clearing pass at reset.
// ---------------------------------------------------------------------------
module jacobi_stencil_sweep #(
  parameter int MAX_COLS   = jss_pkg::MAX_COLS,
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [jss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jss_pkg::CFG_DATA_W-1:0]     cfg_data,
  jss_in_if.sink                             cells,
  jss_out_if.source                          results
);

  localparam int AW = $clog2(MAX_COLS);

  logic [jss_pkg::ROWS_W-1:0]        grid_rows;
  logic [jss_pkg::COLS_W-1:0]        grid_cols;
  logic [jss_pkg::QUEUE_LEVEL_W-1:0] level;
  jss_pkg::push_t                    push;
  logic [VALUE_BITS-1:0]             val_first;
  logic [VALUE_BITS-1:0]             val_second;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [2*VALUE_BITS-1:0]           ram_wdata;
  logic [AW-1:0]                     ram_raddr;
  logic [2*VALUE_BITS-1:0]           ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= jss_pkg::ROWS_W'(jss_pkg::MIN_DIM);
      grid_cols <= jss_pkg::COLS_W'(jss_pkg::MIN_DIM);
    end else if (cfg_write_en) begin
      case (jss_pkg::cfg_index_t'(cfg_index))
        jss_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data[jss_pkg::ROWS_W-1:0];
        jss_pkg::CFG_GRID_COLS: grid_cols <= cfg_data[jss_pkg::COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Line store holding the upper and middle rows.
  jss_ram #(
    .WIDTH (2 * VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Position tracking and stencil arithmetic.
  jss_stencil #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_stencil (
    .clk        (clk),
    .rst        (rst),
    .grid_rows  (grid_rows),
    .grid_cols  (grid_cols),
    .cells      (cells),
    .level      (level),
    .push       (push),
    .val_first  (val_first),
    .val_second (val_second),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Output queue towards the result channel.
  jss_out_queue #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .val_first  (val_first),
    .val_second (val_second),
    .level      (level),
    .results    (results)
  );

endmodule

/* design/jss_ram.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module jss_ram #(
  parameter int WIDTH = 2 * jss_pkg::VALUE_BITS,
  parameter int DEPTH = jss_pkg::MAX_COLS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/jss_out_queue.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep output queue
// Small register queue that takes up to two results per cycle from the
// stencil datapath and hands them out one request at a time.
// ---------------------------------------------------------------------------
module jss_out_queue #(
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  jss_pkg::push_t                      push,
  input  logic [VALUE_BITS-1:0]               val_first,
  input  logic [VALUE_BITS-1:0]               val_second,
  output logic [jss_pkg::QUEUE_LEVEL_W-1:0]   level,
  jss_out_if.source                           results
);

  localparam int DEPTH = jss_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = jss_pkg::QUEUE_LEVEL_W;

  logic [VALUE_BITS-1:0] q_value    [DEPTH];
  logic                  q_run_end  [DEPTH];
  logic                  q_grid_end [DEPTH];
  logic [PW-1:0]         head;
  logic [PW-1:0]         tail;
  logic [PW-1:0]         second_slot;
  logic [LW-1:0]         n_push;
  logic                  pop;

  assign n_push      = LW'(push.first) + LW'(push.second);
  assign pop         = results.valid && results.ready;
  assign second_slot = push.first ? tail + PW'(1) : tail;

  // Entry storage; the row-above cell goes in ahead of the own cell.
  always_ff @(posedge clk) begin
    if (push.first) begin
      q_value[tail]    <= val_first;
      q_run_end[tail]  <= push.first_run_end;
      q_grid_end[tail] <= 1'b0;
    end
    if (push.second) begin
      q_value[second_slot]    <= val_second;
      q_run_end[second_slot]  <= 1'b1;
      q_grid_end[second_slot] <= push.second_grid_end;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      tail  <= tail + n_push[PW-1:0];
      head  <= head + PW'(pop);
      level <= level + n_push - LW'(pop);
    end
  end

  // Head of the queue drives the output channel.
  assign results.valid     = (level != '0);
  assign results.new_value = q_value[head];
  assign results.run_end   = q_run_end[head];
  assign results.grid_end  = q_grid_end[head];

`ifndef SYNTH
  // The queue never holds more entries than it has slots.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(DEPTH))
    else $error("output queue overfilled");

  // An own cell is only ever queued behind the cell of the row above.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("own cell queued without the cell above");
`endif

endmodule

/* design/jss_stencil.sv */
// ---------------------------------------------------------------------------
// Jacobi stencil sweep datapath
// Tracks the grid position, drives the line store RAM one column ahead of
// the incoming cell, and forms the five-point update in a two-step pipeline.
// ---------------------------------------------------------------------------
module jss_stencil #(
  parameter int MAX_COLS   = jss_pkg::MAX_COLS,
  parameter int VALUE_BITS = jss_pkg::VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [jss_pkg::ROWS_W-1:0]          grid_rows,
  input  logic [jss_pkg::COLS_W-1:0]          grid_cols,
  jss_in_if.sink                              cells,
  input  logic [jss_pkg::QUEUE_LEVEL_W-1:0]   level,
  output jss_pkg::push_t                      push,
  output logic [VALUE_BITS-1:0]               val_first,
  output logic [VALUE_BITS-1:0]               val_second,
  output logic                                ram_we,
  output logic [$clog2(MAX_COLS)-1:0]         ram_waddr,
  output logic [2*VALUE_BITS-1:0]             ram_wdata,
  output logic [$clog2(MAX_COLS)-1:0]         ram_raddr,
  input  logic [2*VALUE_BITS-1:0]             ram_rdata
);

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int VB  = VALUE_BITS;
  localparam int RW  = jss_pkg::ROWS_W;
  localparam int LW  = jss_pkg::QUEUE_LEVEL_W;

  // Position registers.
  logic [RW-1:0]   row_pos;
  logic [RW-1:0]   row_pos_next;
  logic [AW-1:0]   col_pos;
  logic [AW-1:0]   col_pos_next;
  logic [AW-1:0]   col_after_next;

  // Effective grid size.
  logic [31:0]     cols_wide;
  logic [CW-1:0]   cols_eff;
  logic [CW-1:0]   cols_last;
  logic [CW-1:0]   cols_held;
  logic [RW-1:0]   rows_eff;
  logic [RW-1:0]   rows_last;

  logic            outside;
  logic [RW-1:0]   row_cur;
  logic [AW-1:0]   col_cur;
  logic            last_col;
  logic            last_row;
  logic            interior;
  logic            accept;

  // Line store entry of the current column ({upper, middle}) and the left
  // neighbour, which is what went to the upper row of the previous column.
  logic [2*VB-1:0] here;
  logic [VB-1:0]   left;
  logic [VB-1:0]   here_upper;
  logic [VB-1:0]   here_middle;
  logic [VB-1:0]   right_middle;

  // Pipeline stage between acceptance and the output queue.
  logic            stg_first;
  logic            stg_second;
  logic            stg_interior;
  logic            stg_run_end;
  logic            stg_grid_end;
  logic [VB:0]     stg_ab;
  logic [VB:0]     stg_cd;
  logic [VB-1:0]   stg_mid;
  logic [VB-1:0]   stg_v;
  logic [VB+1:0]   total;

  // Clamp the configured size to the supported range.
  always_comb begin
    if (32'(grid_cols) < 32'(jss_pkg::MIN_DIM)) begin
      cols_wide = 32'(jss_pkg::MIN_DIM);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_wide = 32'(MAX_COLS);
    end else begin
      cols_wide = 32'(grid_cols);
    end
  end

  assign cols_eff  = cols_wide[CW-1:0];
  assign cols_last = cols_eff - CW'(1);
  assign rows_eff  = (grid_rows < RW'(jss_pkg::MIN_DIM)) ? RW'(jss_pkg::MIN_DIM) : grid_rows;
  assign rows_last = rows_eff - RW'(1);

  // The look-ahead read address depends on the column count, so requests are
  // held off after it changes, until cols_held matches, while the read catches up.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_held <= CW'(jss_pkg::MIN_DIM);
    end else begin
      cols_held <= cols_eff;
    end
  end

  // A position left outside the grid by a size change restarts the grid.
  assign outside  = (row_pos >= rows_eff) || (CW'(col_pos) >= cols_eff);
  assign row_cur  = outside ? '0 : row_pos;
  assign col_cur  = outside ? '0 : col_pos;
  assign last_col = (CW'(col_cur) == cols_last);
  assign last_row = (row_cur == rows_last);
  assign interior = (row_cur > RW'(1)) && (col_cur != '0) && !last_col;

  // Position advance in row-major order.
  assign col_pos_next   = last_col ? '0 : col_cur + AW'(1);
  assign col_after_next = (CW'(col_pos_next) == cols_last) ? '0 : col_pos_next + AW'(1);
  assign row_pos_next   = last_col ? (last_row ? '0 : row_cur + RW'(1)) : row_cur;

  assign accept       = cells.valid && cells.ready;
  assign cells.ready  = (cols_held == cols_eff)
                        && (((LW+1)'(level) + (LW+1)'(stg_first) + (LW+1)'(stg_second))
                            <= (LW+1)'(jss_pkg::QUEUE_DEPTH - 2));

  // The read port always looks one column past the cell to come, so the
  // right neighbour is ready when it arrives.
  assign here_upper   = here[2*VB-1:VB];
  assign here_middle  = here[VB-1:0];
  assign right_middle = ram_rdata[VB-1:0];
  assign ram_raddr    = accept ? col_after_next : col_pos_next;

  // Shift the rows down in the line store: middle becomes upper.
  assign ram_we    = accept;
  assign ram_waddr = col_cur;
  assign ram_wdata = {here_middle, cells.cell_value};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos    <= '0;
      col_pos    <= '0;
      stg_first  <= 1'b0;
      stg_second <= 1'b0;
    end else if (accept) begin
      row_pos    <= row_pos_next;
      col_pos    <= col_pos_next;
      stg_first  <= (row_cur != '0);
      stg_second <= last_row;
    end else begin
      stg_first  <= 1'b0;
      stg_second <= 1'b0;
    end
  end

  // Operand capture and partial sums.
  always_ff @(posedge clk) begin
    if (accept) begin
      here         <= ram_rdata;
      left         <= here_middle;
      stg_interior <= interior;
      stg_run_end  <= !last_row;
      stg_grid_end <= last_col;
      stg_ab       <= {left[VB-1], left} + {here_upper[VB-1], here_upper};
      stg_cd       <= {right_middle[VB-1], right_middle}
                      + {cells.cell_value[VB-1], cells.cell_value};
      stg_mid      <= here_middle;
      stg_v        <= cells.cell_value;
    end
  end

  // Quarter of the neighbour sum, rounded towards minus infinity.
  assign total = {stg_ab[VB], stg_ab} + {stg_cd[VB], stg_cd};

  assign val_first            = stg_interior ? total[VB+1:2] : stg_mid;
  assign val_second           = stg_v;
  assign push.first           = stg_first;
  assign push.second          = stg_second;
  assign push.first_run_end   = stg_run_end;
  assign push.second_grid_end = stg_grid_end;

`ifndef SYNTH
  // Results in flight never outgrow the output queue.
  a_room: assert property (@(posedge clk) disable iff (rst)
    ((LW+1)'(level) + (LW+1)'(stg_first) + (LW+1)'(stg_second))
      <= (LW+1)'(jss_pkg::QUEUE_DEPTH))
    else $error("results in flight exceed queue room");

  // The look-ahead read never hits the entry being rewritten.
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    accept |-> ram_raddr != ram_waddr)
    else $error("line store read and write collide");

  // A row ends by returning to the first column.
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> col_pos == '0)
    else $error("column position did not wrap");
`endif

endmodule
